[hdl/keyed_rotate_add_name_hash_unit_assert.svh]
// Assertion macros for the keyed rotate-add name hash unit.
// Used by the port checker; needs nothing else.
`ifndef KEYED_ROTATE_ADD_NAME_HASH_UNIT_ASSERT_SVH
`define KEYED_ROTATE_ADD_NAME_HASH_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define KRNH_ASSERT_IMPL(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("krnh assertion failed");

// Next-cycle implication, off while reset is asserted.
`define KRNH_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("krnh assertion failed");

// Same-cycle implication that also runs through reset.
`define KRNH_ASSERT_RAW(lbl, a, b) \
	lbl: assert property (@(posedge clk) (a) |-> (b)) \
		else $error("krnh assertion failed");

`endif

[hdl/krnh_pkg.sv]
// Shared constants and helpers for the keyed rotate-add name hash unit.
// No dependencies.
package krnh_pkg;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned ADDR_W = 4;

	// Register map
	localparam logic [ADDR_W-1:0] REG_HASH_KEY = 4'h0;

	// Key after reset
	localparam logic [DATA_W-1:0] KEY_RESET = 64'h0000_0000_FFFF_FFFF;

	// Hash kinds
	localparam logic [1:0] FUNC_NARROW = 2'd0;
	localparam logic [1:0] FUNC_WIDE   = 2'd1;
	localparam logic [1:0] FUNC_PROC   = 2'd2;

	localparam logic [7:0] LOWER_A     = 8'h61;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam logic [7:0] CHAR_NUL    = 8'h00;

	// Fold lower case onto upper case (everything at or above 'a' drops by 0x20)
	function automatic logic [7:0] upcase(input logic [7:0] b);
		return (b >= LOWER_A) ? (b - CASE_OFFSET) : b;
	endfunction

endpackage

[hdl/keyed_rotate_add_name_hash_unit.sv]
// Keyed rotate-add name hash unit: top level with key derivation and hash datapath.
// Depends on krnh_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, func, char_low/high   | request in
//  output  | out_valid, out_stall, name_hash           | request out
//  config  | psel, penable, pwrite, paddr, pwdata, ... | APB write/read
//
// One input request is taken per cycle while in_stall is low; after its terminator is
// accepted, a name hash passes through the input stage into the result register.
// After reset and after every key write the seed and key hashes are derived by a
// sequencer, one key byte per cycle, with in_stall high until it reaches its run state.
// A terminator waits in the input stage while a previous hash is still stalled at
// the output; all other requests pass regardless of out_stall.
module keyed_rotate_add_name_hash_unit #(
	parameter int unsigned HASH_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input requests
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [7:0]                    char_low,
	input  logic [7:0]                    char_high,
	// results
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [63:0]                   name_hash,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [krnh_pkg::ADDR_W-1:0]   paddr,
	input  logic [krnh_pkg::DATA_W-1:0]   pwdata,
	output logic [krnh_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int unsigned W        = 8 * HASH_BYTES;
	localparam int unsigned CW       = (HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1;
	localparam int unsigned ROT_SEED = HASH_BYTES + 1;
	localparam int unsigned ROT_KEY  = HASH_BYTES + 2;
	localparam int unsigned ROT_MOD  = HASH_BYTES + 3;
	localparam int unsigned ROT_PROC = HASH_BYTES + 4;
	localparam logic [CW-1:0] LAST_BYTE = CW'(HASH_BYTES - 1);

	typedef enum logic [1:0] {
		ST_SEED,
		ST_KEY,
		ST_SUM,
		ST_RUN
	} drv_state_t;

	function automatic logic [W-1:0] ror(input logic [W-1:0] v, input int unsigned n);
		return (v >> n) | (v << (W - n));
	endfunction

	// configuration and derivation state
	drv_state_t                  state_q;
	logic [CW-1:0]               cnt_q;
	logic [krnh_pkg::DATA_W-1:0] key_q;
	logic [W-1:0]                drv_h_q;
	logic [W-1:0]                seed_q;
	logic [W-1:0]                sk_sum_q;

	// datapath
	logic                        v_s1;
	logic [1:0]                  func_s1;
	logic [7:0]                  lo_s1;
	logic [7:0]                  hi_s1;
	logic [W-1:0]                running_q;
	logic                        out_valid_q;
	logic [W-1:0]                out_hash_q;

	logic                        cfg_wr;
	logic [7:0]                  key_byte;
	logic [W-1:0]                drv_h_next;
	logic                        in_acc;
	logic                        is_term;
	logic                        adv;
	logic [W-1:0]                lo_up;
	logic [W-1:0]                hi_up;
	logic [W-1:0]                mod_first;
	logic [W-1:0]                fold_h;
	logic [W-1:0]                key_w;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == krnh_pkg::REG_HASH_KEY);
	assign prdata = (paddr == krnh_pkg::REG_HASH_KEY) ? key_q : '0;

	// One rotate-add step of the key fold, key bytes lowest first
	assign key_w      = key_q[W-1:0];
	assign key_byte   = key_w[{cnt_q, 3'b000} +: 8];
	assign drv_h_next = ror(drv_h_q, (state_q == ST_SEED) ? ROT_SEED : ROT_KEY)
		+ W'(key_byte);

	// Terminator detect; selector three is neither a character nor a terminator
	always_comb begin
		case (func_s1)
			krnh_pkg::FUNC_NARROW: is_term = (lo_s1 == krnh_pkg::CHAR_NUL);
			krnh_pkg::FUNC_WIDE:   is_term = (lo_s1 == krnh_pkg::CHAR_NUL)
				&& (hi_s1 == krnh_pkg::CHAR_NUL);
			krnh_pkg::FUNC_PROC:   is_term = (lo_s1 == krnh_pkg::CHAR_NUL);
			default:               is_term = 1'b0;
		endcase
	end

	// A terminator advances only if the result register is free or draining
	assign adv      = v_s1 && (!is_term || !out_valid_q || !out_stall);
	assign in_stall = (state_q != ST_RUN) || (v_s1 && !adv);
	assign in_acc   = in_valid && !in_stall;

	// Character fold
	assign lo_up     = W'(krnh_pkg::upcase(lo_s1));
	assign hi_up     = W'(krnh_pkg::upcase(hi_s1));
	assign mod_first = ror(running_q, ROT_MOD) + lo_up;

	always_comb begin
		case (func_s1)
			krnh_pkg::FUNC_NARROW: fold_h = ror(mod_first, ROT_MOD);
			krnh_pkg::FUNC_WIDE:   fold_h = ror(mod_first, ROT_MOD) + hi_up;
			krnh_pkg::FUNC_PROC:   fold_h = ror(running_q, ROT_PROC) + W'(lo_s1);
			default:               fold_h = running_q;
		endcase
	end

	// Control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SEED;
			cnt_q       <= '0;
			key_q       <= krnh_pkg::KEY_RESET;
			drv_h_q     <= krnh_pkg::KEY_RESET[W-1:0];
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// restart derivation on every key write
			if (cfg_wr) begin
				key_q   <= pwdata;
				drv_h_q <= pwdata[W-1:0];
				cnt_q   <= '0;
				state_q <= ST_SEED;
			end else begin
				case (state_q)
					ST_SEED: begin
						drv_h_q <= drv_h_next;
						cnt_q   <= cnt_q + 1'b1;
						if (cnt_q == LAST_BYTE) begin
							cnt_q   <= '0;
							state_q <= ST_KEY;
						end
					end
					ST_KEY: begin
						drv_h_q <= drv_h_next;
						cnt_q   <= cnt_q + 1'b1;
						if (cnt_q == LAST_BYTE) begin
							cnt_q   <= '0;
							state_q <= ST_SUM;
						end
					end
					ST_SUM: state_q <= ST_RUN;
					default: state_q <= ST_RUN;
				endcase
			end

			// input stage: load on accept, drop when it advances
			if (in_acc)
				v_s1 <= 1'b1;
			else if (adv)
				v_s1 <= 1'b0;

			// result register
			if (adv && is_term)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1 <= func;
			lo_s1   <= char_low;
			hi_s1   <= char_high;
		end

		if (state_q == ST_SEED && cnt_q == LAST_BYTE && !cfg_wr)
			seed_q <= drv_h_next;

		if (state_q == ST_SUM && !cfg_wr) begin
			// drv_h_q holds the key hash here
			sk_sum_q  <= seed_q + drv_h_q;
			running_q <= seed_q;
		end else if (adv) begin
			running_q <= is_term ? seed_q : fold_h;
		end

		if (adv && is_term)
			out_hash_q <= sk_sum_q + running_q;
	end

	assign out_valid = out_valid_q;
	assign name_hash = 64'(out_hash_q);

endmodule

[hdl/krnh_checker.sv]
// Port-level checker for the keyed rotate-add name hash unit, bound to the top level.
// Depends on krnh_pkg and keyed_rotate_add_name_hash_unit_assert.svh.
`include "keyed_rotate_add_name_hash_unit_assert.svh"

module krnh_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [63:0]                 name_hash,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [krnh_pkg::ADDR_W-1:0] paddr,
	input logic                        pready
);

	// hold a stalled result
	`KRNH_ASSERT_NEXT(a_out_valid_hold, out_valid && out_stall, out_valid)
	`KRNH_ASSERT_NEXT(a_out_data_hold, out_valid && out_stall, $stable(name_hash))
	// no request taken while the key is being derived
	`KRNH_ASSERT_RAW(a_stall_after_reset, $past(!arst_n), in_stall)
	`KRNH_ASSERT_NEXT(a_stall_after_key,
		psel && penable && pwrite && pready && (paddr == krnh_pkg::REG_HASH_KEY), in_stall)
	`KRNH_ASSERT_IMPL(a_pready_high, psel && penable, pready)

endmodule

bind keyed_rotate_add_name_hash_unit krnh_checker u_krnh_checker (.*);

[tb/sv/name_hash_check_pkg.sv]
// Scoreboard for the keyed rotate-add name hash unit: predicts name hashes and checks results.
// Depends on krnh_pkg for the key reset value, hash kinds and case-folding constants.
package name_hash_check_pkg;

	// Selector value with no hash kind behind it; the block drops such requests
	localparam logic [1:0] FUNC_NONE = 2'd3;

	class name_hash_board #(int unsigned HASH_BYTES = 8);
		localparam int unsigned WIDTH = 8 * HASH_BYTES;

		bit [63:0] hash_mask;
		bit [63:0] hash_key;
		bit [63:0] seed_hash;
		bit [63:0] key_hash;
		bit [63:0] running_hash;
		bit [63:0] pending_hashes[$];
		int unsigned errors;

		function new();
			hash_mask = {64{1'b1}} >> (64 - WIDTH);
			errors = 0;
			load_key(krnh_pkg::KEY_RESET);
		endfunction

		function bit [63:0] rotr(bit [63:0] v, int unsigned n);
			v &= hash_mask;
			return ((v >> n) | (v << (WIDTH - n))) & hash_mask;
		endfunction

		// Fold the key bytes, lowest first, into a start value
		function bit [63:0] fold_key_bytes(bit [63:0] start, bit [63:0] k, int unsigned n);
			bit [63:0] h;
			h = start & hash_mask;
			for (int unsigned i = 0; i < HASH_BYTES; i++) begin
				h = rotr(h, n);
				h = (h + ((k >> (8 * i)) & 64'hff)) & hash_mask;
			end
			return h;
		endfunction

		function bit [7:0] fold_case(bit [7:0] b);
			return (b >= krnh_pkg::LOWER_A) ? b - krnh_pkg::CASE_OFFSET : b;
		endfunction

		// A key write derives both hashes again and restarts the current name
		function void load_key(bit [63:0] k);
			bit [63:0] kw;
			hash_key = k;
			kw = k & hash_mask;
			seed_hash = fold_key_bytes(kw, kw, HASH_BYTES + 1);
			key_hash = fold_key_bytes(seed_hash, kw, HASH_BYTES + 2);
			running_hash = seed_hash;
		endfunction

		function void note_request(bit [1:0] f, bit [7:0] lo, bit [7:0] hi);
			bit terminator;
			bit [63:0] h;
			if (f == FUNC_NONE)
				return;
			if (f == krnh_pkg::FUNC_WIDE)
				terminator = (lo == krnh_pkg::CHAR_NUL) && (hi == krnh_pkg::CHAR_NUL);
			else
				terminator = (lo == krnh_pkg::CHAR_NUL);
			if (terminator) begin
				pending_hashes.push_back((seed_hash + key_hash + running_hash) & hash_mask);
				running_hash = seed_hash;
				return;
			end
			h = running_hash;
			case (f)
				krnh_pkg::FUNC_NARROW: begin
					h = (rotr(h, HASH_BYTES + 3) + fold_case(lo)) & hash_mask;
					h = rotr(h, HASH_BYTES + 3);
				end
				krnh_pkg::FUNC_WIDE: begin
					h = (rotr(h, HASH_BYTES + 3) + fold_case(lo)) & hash_mask;
					h = (rotr(h, HASH_BYTES + 3) + fold_case(hi)) & hash_mask;
				end
				default: begin
					h = (rotr(h, HASH_BYTES + 4) + lo) & hash_mask;
				end
			endcase
			running_hash = h;
		endfunction

		task report(string msg);
			errors++;
			$display("ERROR: %s", msg);
		endtask

		task check_hash(bit [63:0] got);
			bit [63:0] want;
			if (pending_hashes.size() == 0) begin
				report($sformatf("name hash %h with none outstanding", got));
				return;
			end
			want = pending_hashes.pop_front();
			if (got != want)
				report($sformatf("name_hash %h, predicted %h", got, want));
		endtask

		function int unsigned pending();
			return pending_hashes.size();
		endfunction
	endclass

endpackage

[tb/sv/testbench.sv]
// Top-level testbench for the keyed rotate-add name hash unit: directed names, then random ones.
// Depends on krnh_pkg, name_hash_check_pkg and the keyed_rotate_add_name_hash_unit RTL.
module testbench;
	import krnh_pkg::*;
	import name_hash_check_pkg::*;

	localparam int unsigned HASH_BYTES = 8;
	// Requests per random phase, four phases
	localparam int unsigned PHASE_REQUESTS = 225;
	// Result passes the input stage and the result register; leave margin for in-flight characters
	localparam int unsigned DRAIN_CYCLES = 8;
	// Long receiver hold-off so that the block backs up into its input
	localparam int unsigned HOLD_OFF_CYCLES = 400;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          func = FUNC_NARROW;
	logic [7:0]          char_low = CHAR_NUL;
	logic [7:0]          char_high = CHAR_NUL;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [63:0]         name_hash;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = REG_HASH_KEY;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	name_hash_board #(HASH_BYTES) board;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_left = 0;
	int unsigned sent_count = 0;

	keyed_rotate_add_name_hash_unit #(
		.HASH_BYTES(HASH_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.char_low(char_low),
		.char_high(char_high),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.name_hash(name_hash),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: hold stall through a requested hold-off, else stall at random.
	// The hold-off is counted down here, one cycle per falling edge.
	initial begin : receiver
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Take each result at the edge where it is handed over
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_hash(name_hash);
	end

	// Offer one request, idling first at random; return once it is accepted.
	// Valid is only lowered here while idling, so it never drops and rises in one step.
	task automatic send_request(input logic [1:0] f, input logic [7:0] lo, input logic [7:0] hi);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		char_low <= lo;
		char_high <= hi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_request(f, lo, hi);
		if (f != FUNC_NONE)
			sent_count++;
	endtask

	// Drop valid, wait for every predicted hash, then let trailing characters settle
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the key (setup then access), then read it back the same way
	task automatic write_key(input logic [63:0] k);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_HASH_KEY;
		pwdata <= k;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		board.load_key(k);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== k)
			board.report($sformatf("hash_key reads %h, written %h", prdata, k));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Name characters: letters of both cases, the bytes around 'a', or any nonzero byte
	function automatic logic [7:0] pick_char();
		case ($urandom_range(3))
			0: return 8'(8'h61 + $urandom_range(25));
			1: return 8'(8'h41 + $urandom_range(25));
			2: return 8'($urandom_range(255, 1));
			default: return 8'(8'h5f + $urandom_range(4));
		endcase
	endfunction

	// Terminator for a hash kind; high byte only matters for wide names
	task automatic end_name(input logic [1:0] f);
		send_request(f, CHAR_NUL, (f == FUNC_WIDE) ? CHAR_NUL : 8'($urandom));
	endtask

	// One random name: mostly well-formed with one hash kind, some with the kind
	// switching mid-name, the rest raw noise that may or may not terminate
	task automatic send_name();
		int unsigned shape;
		int unsigned len;
		logic [1:0] f;
		logic [7:0] lo;
		logic [7:0] hi;
		shape = $urandom_range(99);
		len = $urandom_range(12);
		if (shape < 80) begin
			f = 2'($urandom_range(2));
			for (int unsigned i = 0; i < len; i++) begin
				if ($urandom_range(19) == 0)
					send_request(FUNC_NONE, 8'($urandom), 8'($urandom));
				lo = pick_char();
				hi = 8'($urandom);
				if (f == FUNC_WIDE && $urandom_range(1) == 0)
					hi = CHAR_NUL;
				// wide character with only its high byte set is not a terminator
				if (f == FUNC_WIDE && $urandom_range(7) == 0) begin
					lo = CHAR_NUL;
					hi = 8'($urandom_range(255, 1));
				end
				send_request(f, lo, hi);
			end
			end_name(f);
		end else if (shape < 90) begin
			for (int unsigned i = 0; i < len; i++)
				send_request(2'($urandom_range(2)), pick_char(), 8'($urandom));
			end_name(2'($urandom_range(2)));
		end else begin
			for (int unsigned i = 0; i <= len % 4; i++) begin
				lo = ($urandom_range(3) == 0) ? CHAR_NUL : 8'($urandom);
				hi = ($urandom_range(3) == 0) ? CHAR_NUL : 8'($urandom);
				send_request(2'($urandom), lo, hi);
			end
		end
	endtask

	task automatic run_phase(input int unsigned requests);
		sent_count = 0;
		while (sent_count < requests)
			send_name();
		settle();
	endtask

	initial begin
		board = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed names under the reset key, no idling on either side.
		// Narrow: the bytes around 'a', top byte, high byte ignored on the terminator too
		send_request(FUNC_NARROW, 8'h61, 8'hff);
		send_request(FUNC_NARROW, 8'h60, 8'h00);
		send_request(FUNC_NARROW, 8'hff, 8'h80);
		send_request(FUNC_NARROW, 8'h7a, 8'h00);
		send_request(FUNC_NARROW, 8'h01, 8'h7f);
		send_request(FUNC_NARROW, CHAR_NUL, 8'hff);
		// Selector three is dropped
		send_request(FUNC_NONE, 8'hff, 8'hff);
		send_request(FUNC_NONE, CHAR_NUL, CHAR_NUL);
		// Wide: a lone high byte does not terminate, both bytes fold case
		send_request(FUNC_WIDE, CHAR_NUL, 8'h61);
		send_request(FUNC_WIDE, 8'h61, CHAR_NUL);
		send_request(FUNC_WIDE, 8'hff, 8'hff);
		send_request(FUNC_WIDE, 8'h80, 8'h7f);
		send_request(FUNC_WIDE, CHAR_NUL, CHAR_NUL);
		// Procedure: no case folding, high byte ignored
		send_request(FUNC_PROC, 8'h61, 8'h00);
		send_request(FUNC_PROC, 8'hff, 8'hff);
		send_request(FUNC_PROC, 8'h01, 8'h33);
		send_request(FUNC_PROC, CHAR_NUL, 8'h55);
		// Kind switches mid-name; running hash carries over
		send_request(FUNC_NARROW, 8'h78, 8'h00);
		send_request(FUNC_PROC, 8'h79, 8'h00);
		send_request(FUNC_WIDE, 8'h7a, CHAR_NUL);
		send_request(FUNC_NARROW, CHAR_NUL, 8'h01);
		// Empty name
		send_request(FUNC_PROC, CHAR_NUL, CHAR_NUL);
		// Key rewritten mid-name: the name restarts from the new seed
		send_request(FUNC_WIDE, 8'h71, 8'h01);
		settle();
		write_key({$urandom, $urandom});
		send_request(FUNC_WIDE, CHAR_NUL, CHAR_NUL);
		settle();

		// All-zero key, no idling, long receiver hold-off at the start
		write_key(64'h0);
		hold_left = HOLD_OFF_CYCLES;
		run_phase(PHASE_REQUESTS);

		// All-ones key, sender mostly idle
		write_key({64{1'b1}});
		send_idle_pct = 86;
		recv_stall_pct = 0;
		run_phase(PHASE_REQUESTS);

		// Random key, receiver mostly stalled
		write_key({$urandom, $urandom});
		send_idle_pct = 0;
		recv_stall_pct = 86;
		run_phase(PHASE_REQUESTS);

		// Top and bottom key bits only, light idling on both sides
		write_key(64'h8000_0000_0000_0001);
		send_idle_pct = 12;
		recv_stall_pct = 12;
		run_phase(PHASE_REQUESTS);

		if (board.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Backstop for a hung handshake or a result that never arrives
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
